>>> design/smf_pkg.sv
package smf_pkg;

  localparam int unsigned SAMPLE_W = 16;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

>>> design/smf_window.sv
module smf_window #(
  parameter int unsigned WINDOW = 11
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    wr_en_i,
  input  smf_pkg::sample_t                        sample_i,
  output logic [WINDOW-1:0][smf_pkg::SAMPLE_W-1:0] win_o
);

  localparam int unsigned PosW = $clog2(WINDOW);
  localparam logic [PosW-1:0] PosLast = PosW'(WINDOW - 1);

  logic [WINDOW-1:0][smf_pkg::SAMPLE_W-1:0] win_q;
  logic [PosW-1:0]                           pos_q, pos_d;

  assign pos_d = (pos_q == PosLast) ? '0 : pos_q + PosW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
      pos_q <= '0;
    end else if (wr_en_i) begin
      win_q[pos_q] <= sample_i;
      pos_q        <= pos_d;
    end
  end

  assign win_o = win_q;

endmodule

>>> design/smf_rank_select.sv
module smf_rank_select #(
  parameter int unsigned WINDOW = 11
) (
  input  logic [WINDOW-1:0][smf_pkg::SAMPLE_W-1:0] win_i,
  output smf_pkg::sample_t                          median_o
);

  localparam int unsigned CntW = $clog2(WINDOW + 1);
  localparam logic [CntW-1:0] MidRank = CntW'(WINDOW / 2);

  logic [CntW-1:0] below  [WINDOW];
  logic [CntW-1:0] below_eq [WINDOW];
  logic [WINDOW-1:0] hit;

  // every entry counts how many entries sit strictly below it and how many at or below
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      below[i]    = '0;
      below_eq[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        below[i]    = below[i] + CntW'(win_i[j] < win_i[i]);
        below_eq[i] = below_eq[i] + CntW'(win_i[j] <= win_i[i]);
      end
      hit[i] = (below[i] <= MidRank) && (MidRank < below_eq[i]);
    end
  end

  // all hits carry the same value, so an OR of the masked entries picks it
  always_comb begin
    median_o = '0;
    for (int i = 0; i < WINDOW; i++) begin
      median_o = median_o | (win_i[i] & {smf_pkg::SAMPLE_W{hit[i]}});
    end
  end

endmodule

>>> design/sliding_median_filter.sv
// Running median over the last WINDOW samples.
// Path: beat into the window registers, its median into out_q once the output slot frees.
// One sample per cycle unless stalled; one rank-and-select pass over the window registers.
// Reset: window entries and write position clear to zero, no result pending;
// until WINDOW samples have arrived the zero entries take part in the median.
module sliding_median_filter #(
  parameter int unsigned WINDOW = 11
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // [15:0] median
);

  logic [WINDOW-1:0][smf_pkg::SAMPLE_W-1:0] win;
  smf_pkg::sample_t median;
  logic             in_beat;
  logic             pend_q;   // window holds a sample whose median is not yet taken up
  logic             out_vld_q;
  smf_pkg::sample_t out_q;
  logic             adv;

  assign adv           = pend_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !pend_q || adv;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  smf_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (in_beat),
    .sample_i (s_axis_tdata),
    .win_o    (win)
  );

  smf_rank_select #(
    .WINDOW (WINDOW)
  ) u_rank (
    .win_i    (win),
    .median_o (median)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_beat) begin
        pend_q <= 1'b1;
      end else if (adv) begin
        pend_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= median;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef smf_pkg::sample_t sample_t;

  localparam int unsigned WIN_LEN     = 11;
  localparam int unsigned RAND_BEATS  = 1500;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef struct packed {
    sample_t sample;
    logic    typed;   // median below is fixed by hand, else use the predictor
    sample_t median;
  } stim_row_t;

  typedef struct packed {
    logic    typed;
    sample_t median;
  } row_note_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    s_axis_tvalid = 1'b0;
  logic    s_axis_tready;
  sample_t s_axis_tdata = '0;   // [15:0] sample
  logic    m_axis_tvalid;
  logic    m_axis_tready = 1'b0;
  sample_t m_axis_tdata;        // [15:0] median

  sliding_median_filter #(
    .WINDOW(WIN_LEN)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Start-up fill: six full-scale samples against five zeros flip the median
  // on the sixth beat. Then extremes, bit patterns and a run of duplicates.
  stim_row_t dir_rows [0:20] = '{
    '{16'hFFFF, 1'b1, 16'h0000}, '{16'hFFFF, 1'b1, 16'h0000},
    '{16'hFFFF, 1'b1, 16'h0000}, '{16'hFFFF, 1'b1, 16'h0000},
    '{16'hFFFF, 1'b1, 16'h0000}, '{16'hFFFF, 1'b1, 16'hFFFF},
    '{16'h0000, 1'b0, 16'h0000}, '{16'h0001, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 16'h0000}, '{16'h7FFF, 1'b0, 16'h0000},
    '{16'hAAAA, 1'b0, 16'h0000}, '{16'h5555, 1'b0, 16'h0000},
    '{16'hFFFE, 1'b0, 16'h0000}, '{16'h0040, 1'b0, 16'h0000},
    '{16'h0040, 1'b0, 16'h0000}, '{16'h0040, 1'b0, 16'h0000},
    '{16'h0040, 1'b0, 16'h0000}, '{16'h0040, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b0, 16'h0000}, '{16'h0000, 1'b0, 16'h0000},
    '{16'h0001, 1'b0, 16'h0000}
  };

  sample_t     win_q [WIN_LEN];
  int unsigned wr_pos;
  sample_t     medians_due [$];
  row_note_t   row_notes [$];

  int unsigned tx_idle_pct, rx_idle_pct;
  bit          hold_pending;
  int unsigned samples_in, medians_out, mismatch_count, quiet_cycles;

  // Entry of rank WIN_LEN/2 counted from the smallest; duplicates rank apart.
  function automatic sample_t median_of_window();
    int unsigned below, not_above;
    for (int i = 0; i < WIN_LEN; i++) begin
      below     = 0;
      not_above = 0;
      for (int j = 0; j < WIN_LEN; j++) begin
        if (win_q[j] < win_q[i]) below++;
        if (win_q[j] <= win_q[i]) not_above++;
      end
      if (below <= WIN_LEN / 2 && WIN_LEN / 2 < not_above) return win_q[i];
    end
    return '0;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic push_sample(input sample_t value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Sink side: random stalls, plus one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    sample_t   want;
    row_note_t note;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        win_q[wr_pos] = s_axis_tdata;
        wr_pos = (wr_pos == WIN_LEN - 1) ? 0 : wr_pos + 1;
        want = median_of_window();
        if (row_notes.size() != 0) begin
          note = row_notes.pop_front();
          if (note.typed) want = note.median;
        end
        medians_due.push_back(want);
        samples_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        medians_out++;
        if (medians_due.size() == 0) begin
          $display("%0t: unexpected median beat, expected none, got %h", $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          want = medians_due.pop_front();
          if (m_axis_tdata !== want) begin
            $display("%0t: median mismatch, expected %h, got %h", $time, want, m_axis_tdata);
            mismatch_count++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d medians outstanding",
                 $time, QUIET_LIMIT, medians_due.size());
        $display("** sliding_median_filter: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    sample_t value;
    foreach (win_q[i]) win_q[i] = '0;
    wr_pos      = 0;
    tx_idle_pct = 9;
    rx_idle_pct = 76;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      row_notes.push_back('{dir_rows[i].typed, dir_rows[i].median});
      push_sample(dir_rows[i].sample);
    end

    for (int n = 0; n < RAND_BEATS; n++) begin
      if (n == RAND_BEATS / 3) begin
        tx_idle_pct = 76;
        rx_idle_pct = 9;
      end else if (n == 2 * RAND_BEATS / 3) begin
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_pending = 1'b1;
      end
      case ($urandom_range(9)) inside
        0:       value = sample_t'(1) << $urandom_range(15);
        1:       value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        // narrow spread so that equal values crowd the window
        2, 3:    value = sample_t'(16'h1000 + ($urandom_range(3) << 6));
        default: value = sample_t'($urandom_range(16'hFFFF));
      endcase
      push_sample(value);
    end
    s_axis_tvalid <= 1'b0;

    while (medians_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("%0d samples sent (%0d directed, rest random over three stall mixes, one hold-off)",
             samples_in, $size(dir_rows));
    $display("%0d medians checked, %0d mismatches", medians_out, mismatch_count);
    if (mismatch_count == 0) begin
      $display("** sliding_median_filter: PASSED **");
    end else begin
      $display("** sliding_median_filter: FAILED **");
    end
    $finish;
  end

endmodule
